// ===== hw/rtl/fwg_pkg.sv =====
package fwg_pkg;

  localparam int MAX_TAPS_DEF = 64;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int COEFF_W  = 18;
  localparam int TAPIX_W  = 6;
  localparam int TAPS_W   = 7;
  localparam int PROD_W   = SAMPLE_W + COEFF_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd4096;
  localparam logic [TAPS_W-1:0]   TAPS_RESET = 7'd64;
  localparam logic signed [SAMPLE_W-1:0] Q23_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] Q23_MIN = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_GAIN  = 2'd0,
    REG_OUTPUT_GAIN = 2'd1,
    REG_BIAS_LEVEL  = 2'd2,
    REG_ACTIVE_TAPS = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_LOAD   = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SETTLE,
    ST_LAUNCH,
    ST_SWEEP,
    ST_ROUND,
    ST_GAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                      shift;
    logic                      load_en;
    logic [TAPIX_W-1:0]        load_index;
    logic signed [COEFF_W-1:0] load_value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/fwg_cell.sv =====
module fwg_cell
  import fwg_pkg::*;
#(
  parameter int K     = 0,
  parameter int ACC_W = 49
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cell_ctrl_t                 ctrl,
  input  logic [TAPS_W-1:0]          active_taps,
  input  logic signed [SAMPLE_W-1:0] data_in,
  output logic signed [SAMPLE_W-1:0] data_out,
  input  logic signed [ACC_W-1:0]    psum_in,
  input  logic                       psum_vin,
  output logic signed [ACC_W-1:0]    psum_out,
  output logic                       psum_vout
);

  logic signed [SAMPLE_W-1:0] data;
  logic signed [COEFF_W-1:0]  coeff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    psum;
  logic                       vout;
  logic                       tap_on;
  logic                       load_hit;
  logic signed [ACC_W-1:0]    addend;

  assign tap_on   = 32'(K) < 32'(active_taps);
  assign load_hit = ctrl.load_en && (32'(K) == 32'(ctrl.load_index));
  assign addend   = tap_on ? {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      data  <= '0;
      coeff <= '0;
      vout  <= 1'b0;
    end else begin
      if (ctrl.shift) begin
        data <= data_in;
      end
      if (load_hit) begin
        coeff <= ctrl.load_value;
      end
      vout <= psum_vin;
    end
  end

  // tap product, held stable while the delay line is still
  always_ff @(posedge clk) begin
    prod <= coeff * data;
    if (psum_vin) begin
      psum <= psum_in + addend;
    end
  end

  assign data_out  = data;
  assign psum_out  = psum;
  assign psum_vout = vout;

endmodule

// ===== hw/rtl/fir_filter_with_gain.sv =====
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    req_type, sample_in, tap_index, coeff_value
// out       output     out_valid / out_ready  sample_out, clipped
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a coefficient load gives no result
// for a sample, the partial sum walks the tap cell row one cell a cycle
// one sample is in work at a time; the next request waits until its result sits in the
// output register, and a stalled output holds the last stage only
// reset clears the delay line, the coefficients and the registers to their defaults
module fir_filter_with_gain
  import fwg_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic signed [SAMPLE_W-1:0]   sample_in,
  input  logic [TAPIX_W-1:0]           tap_index,
  input  logic signed [COEFF_W-1:0]    coeff_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_W-1:0]   sample_out,
  output logic                         clipped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int MID_W  = ACC_W + 1 - 16;
  localparam int GP_W   = MID_W + GAIN_W + 1;
  localparam int INP_W  = SAMPLE_W + GAIN_W + 1;

  state_t state, state_next;

  logic [GAIN_W-1:0]          in_gain;
  logic [GAIN_W-1:0]          out_gain;
  logic signed [SAMPLE_W-1:0] bias_level;
  logic [TAPS_W-1:0]          active_taps;

  logic signed [INP_W-1:0]    in_prod;
  logic signed [SAMPLE_W-1:0] x_sat;
  logic                       x_hit;
  logic                       hit_in;
  logic signed [MID_W-1:0]    mid;
  logic signed [GP_W-1:0]     gprod;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       y_hit;

  logic       launch;
  logic       emit_fire;
  logic       in_fire;
  cell_ctrl_t ctrl;

  logic signed [SAMPLE_W-1:0] dchain [MAX_TAPS];
  logic signed [ACC_W-1:0]    psum   [MAX_TAPS+1];
  logic                       pv     [MAX_TAPS+1];

  // input scaling: round half up, saturate
  logic signed [INP_W:0]    in_t;
  logic signed [INP_W-12:0] in_s;
  assign in_t = {in_prod[INP_W-1], in_prod} + (INP_W+1)'(2048);
  assign in_s = in_t[INP_W:12];
  always_comb begin
    x_hit = 1'b0;
    x_sat = in_s[SAMPLE_W-1:0];
    if (in_s > (INP_W-11)'(Q23_MAX)) begin
      x_hit = 1'b1;
      x_sat = Q23_MAX;
    end else if (in_s < (INP_W-11)'(Q23_MIN)) begin
      x_hit = 1'b1;
      x_sat = Q23_MIN;
    end
  end

  // output scaling: round half up, saturate
  logic signed [GP_W:0]    out_t;
  logic signed [GP_W-12:0] out_s;
  assign out_t = {gprod[GP_W-1], gprod} + (GP_W+1)'(2048);
  assign out_s = out_t[GP_W:12];
  always_comb begin
    y_hit = 1'b0;
    y_sat = out_s[SAMPLE_W-1:0];
    if (out_s > (GP_W-11)'(Q23_MAX)) begin
      y_hit = 1'b1;
      y_sat = Q23_MAX;
    end else if (out_s < (GP_W-11)'(Q23_MIN)) begin
      y_hit = 1'b1;
      y_sat = Q23_MIN;
    end
  end

  logic signed [ACC_W:0] acc_t;
  assign acc_t = {psum[MAX_TAPS][ACC_W-1], psum[MAX_TAPS]} + (ACC_W+1)'(32768);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (req_type == REQ_SAMPLE)) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT:  state_next = ST_SETTLE;
      ST_SETTLE: state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (pv[MAX_TAPS]) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready        = (state == ST_IDLE);
    launch          = (state == ST_LAUNCH);
    emit_fire       = (state == ST_EMIT) && (!out_valid || out_ready);
    in_fire         = in_valid && in_ready;
    ctrl.shift      = (state == ST_SHIFT);
    ctrl.load_en    = in_fire && (req_type == REQ_LOAD);
    ctrl.load_index = tap_index;
    ctrl.load_value = coeff_value;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      in_gain     <= GAIN_RESET;
      out_gain    <= GAIN_RESET;
      bias_level  <= '0;
      active_taps <= TAPS_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_INPUT_GAIN:  in_gain     <= cfg_data[GAIN_W-1:0];
          REG_OUTPUT_GAIN: out_gain    <= cfg_data[GAIN_W-1:0];
          REG_BIAS_LEVEL:  bias_level  <= cfg_data[SAMPLE_W-1:0];
          REG_ACTIVE_TAPS: active_taps <= cfg_data[TAPS_W-1:0];
          default: ;
        endcase
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_prod <= sample_in * $signed({1'b0, in_gain});
    end
    if (ctrl.shift) begin
      hit_in <= x_hit;
    end
    if (state == ST_ROUND) begin
      mid <= acc_t[ACC_W:16];
    end
    if (state == ST_GAIN) begin
      gprod <= mid * $signed({1'b0, out_gain});
    end
    if (emit_fire) begin
      sample_out <= y_sat;
      clipped    <= hit_in | y_hit;
    end
  end

  assign dchain[0] = x_sat;
  assign psum[0]   = {{(ACC_W-SAMPLE_W-16){bias_level[SAMPLE_W-1]}}, bias_level, 16'b0};
  assign pv[0]     = launch;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    if (k < MAX_TAPS - 1) begin : g_mid
      fwg_cell #(
        .K     (k),
        .ACC_W (ACC_W)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .active_taps (active_taps),
        .data_in     (dchain[k]),
        .data_out    (dchain[k+1]),
        .psum_in     (psum[k]),
        .psum_vin    (pv[k]),
        .psum_out    (psum[k+1]),
        .psum_vout   (pv[k+1])
      );
    end else begin : g_last
      fwg_cell #(
        .K     (k),
        .ACC_W (ACC_W)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .active_taps (active_taps),
        .data_in     (dchain[k]),
        .data_out    (),
        .psum_in     (psum[k]),
        .psum_vin    (pv[k]),
        .psum_out    (psum[k+1]),
        .psum_vout   (pv[k+1])
      );
    end
  end

endmodule
